@@ hdl/elt_pkg.sv @@
`timescale 1ns / 1ps
package elt_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int NODE_BITS_DEF   = 8;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int NODE_FIELD_W  = 8;
  localparam int WT_FIELD_W    = 16;
  localparam int COUNT_W       = 5;
  localparam int SUM_W         = 20;
  localparam int IN_DATA_W     = 32;
  localparam int IN_USER_W     = 2;
  localparam int OUT_DATA_W    = 32;

  localparam logic [1:0] REQ_APPEND  = 2'd0;
  localparam logic [1:0] REQ_PREPEND = 2'd1;
  localparam logic [1:0] REQ_DELETE  = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

endpackage

@@ hdl/elt_ctrl.sv @@
`timescale 1ns / 1ps
module elt_ctrl
  import elt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  output ctl_t ctl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;
  logic out_valid_next;

  always_comb begin
    ctl.load       = 1'b0;
    ctl.exec       = 1'b0;
    state_next     = state;
    out_valid_next = out_valid;
    if (m_tready) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid || m_tready) begin
          ctl.exec       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

endmodule

@@ hdl/elt_dp.sv @@
`timescale 1ns / 1ps
module elt_dp
  import elt_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int NODE_BITS   = NODE_BITS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_t                  ctl,
  input  logic [IN_USER_W-1:0]  s_tuser,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  logic [NODE_BITS-1:0]          src_cell [CAPACITY];
  logic [NODE_BITS-1:0]          dst_cell [CAPACITY];
  logic signed [WEIGHT_BITS-1:0] wt_cell  [CAPACITY];

  logic [CNT_BITS-1:0] fill;
  logic [CNT_BITS-1:0] fill_next;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    sum_next;

  logic [1:0]                    req_type;
  logic [NODE_BITS-1:0]          req_src;
  logic [NODE_BITS-1:0]          req_dst;
  logic signed [WEIGHT_BITS-1:0] req_wt;
  logic [CAPACITY-1:0]           match;

  logic [1:0]         out_status;
  logic [COUNT_W-1:0] out_count;
  logic [SUM_W-1:0]   out_sum;

  logic [15:0]                   in_src_wide;
  logic [15:0]                   in_dst_wide;
  logic signed [31:0]            in_wt_wide;
  logic [NODE_BITS-1:0]          in_src;
  logic [NODE_BITS-1:0]          in_dst;
  logic [CAPACITY-1:0]           match_in;

  logic                          is_ins;
  logic                          full;
  logic                          hit;
  logic [CAPACITY-1:0]           past_hit;
  logic [CAPACITY-1:0]           first_hit;
  logic signed [WEIGHT_BITS-1:0] del_wt;
  logic signed [31:0]            req_wt_wide;
  logic signed [31:0]            del_wt_wide;
  logic [1:0]                    status_next;
  logic                          do_ins;
  logic                          do_del;

  assign in_src_wide = 16'(s_tdata[NODE_FIELD_W-1:0]);
  assign in_dst_wide = 16'(s_tdata[2*NODE_FIELD_W-1:NODE_FIELD_W]);
  assign in_wt_wide  = 32'(signed'(s_tdata[2*NODE_FIELD_W+WT_FIELD_W-1:2*NODE_FIELD_W]));
  assign in_src      = in_src_wide[NODE_BITS-1:0];
  assign in_dst      = in_dst_wide[NODE_BITS-1:0];

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_in[i] = (CNT_BITS'(i) < fill) && (src_cell[i] == in_src) &&
                    (dst_cell[i] == in_dst);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_type <= s_tuser;
      req_src  <= in_src;
      req_dst  <= in_dst;
      req_wt   <= in_wt_wide[WEIGHT_BITS-1:0];
      match    <= match_in;
    end
  end

  always_comb begin
    past_hit[0] = match[0];
    for (int i = 1; i < CAPACITY; i++) begin
      past_hit[i] = past_hit[i-1] | match[i];
    end
    first_hit[0] = match[0];
    for (int i = 1; i < CAPACITY; i++) begin
      first_hit[i] = match[i] & ~past_hit[i-1];
    end
    del_wt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      del_wt = del_wt | (first_hit[i] ? wt_cell[i] : '0);
    end
  end

  assign hit         = past_hit[CAPACITY-1];
  assign is_ins      = (req_type == REQ_APPEND) || (req_type == REQ_PREPEND);
  assign full        = (fill == CNT_BITS'(CAPACITY));
  assign do_ins      = is_ins && !full;
  assign do_del      = (req_type == REQ_DELETE) && hit;
  assign req_wt_wide = 32'(req_wt);
  assign del_wt_wide = 32'(del_wt);

  always_comb begin
    fill_next   = fill;
    sum_next    = sum;
    status_next = ST_DONE;
    if (is_ins && full) begin
      status_next = ST_FULL;
    end else if (req_type == REQ_DELETE && !hit) begin
      status_next = ST_MISSING;
    end
    if (do_ins) begin
      fill_next = fill + 1'b1;
      sum_next  = sum + req_wt_wide[SUM_W-1:0];
    end else if (do_del) begin
      fill_next = fill - 1'b1;
      sum_next  = sum - del_wt_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      sum  <= '0;
    end else if (ctl.exec) begin
      fill <= fill_next;
      sum  <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      out_status <= status_next;
      out_count  <= COUNT_W'(fill_next);
      out_sum    <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_ins && req_type == REQ_APPEND && CNT_BITS'(i) == fill) begin
          src_cell[i] <= req_src;
          dst_cell[i] <= req_dst;
          wt_cell[i]  <= req_wt;
        end else if (do_ins && req_type == REQ_PREPEND) begin
          if (i == 0) begin
            src_cell[i] <= req_src;
            dst_cell[i] <= req_dst;
            wt_cell[i]  <= req_wt;
          end else begin
            src_cell[i] <= src_cell[i-1];
            dst_cell[i] <= dst_cell[i-1];
            wt_cell[i]  <= wt_cell[i-1];
          end
        end else if (do_del && past_hit[i] && i < CAPACITY - 1) begin
          src_cell[i] <= src_cell[i+1];
          dst_cell[i] <= dst_cell[i+1];
          wt_cell[i]  <= wt_cell[i+1];
        end
      end
    end
  end

  assign m_tdata = OUT_DATA_W'({out_sum, out_count, out_status});

endmodule

@@ hdl/edge_list_table_top.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Signals                      Fields (low bit up)
// s_*      in   tvalid tready tdata tuser    tuser: req_type; tdata: src_node dst_node edge_weight
// m_*      out  tvalid tready tdata          tdata: status entry_count total_weight
//
// Each request has two steps: accept, where all entries are matched and the result registered,
// then execute in the cell chain, where the first hit is found and the chain shifts in one step.
// The result sits in an output register; the next request is taken while it waits.
// A stalled result holds the chain in the execute cycle until the register frees.
// rst is synchronous, active high; it empties the table and clears the sum.
module edge_list_table_top
  import elt_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int NODE_BITS   = NODE_BITS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // src_node[7:0] dst_node[15:8] edge_weight[31:16]
  input  logic [IN_USER_W-1:0]  s_tuser,  // req_type[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata   // status[1:0] entry_count[6:2] total_weight[26:7]
);

  ctl_t ctl;

  elt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctl      (ctl)
  );

  elt_dp #(
    .CAPACITY    (CAPACITY),
    .NODE_BITS   (NODE_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .s_tuser (s_tuser),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata)
  );

  a_exec_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.exec |=> m_tvalid)
    else $error("result not presented after execute");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken before the first executed");

  a_load_exec_apart: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> !ctl.exec)
    else $error("load and execute in the same cycle");

endmodule
